@@ hdl/ssal_pkg.sv @@
// Shared constants for the sampled suffix array lookup block.
// Holds field widths, action codes and status codes; depends on nothing.
`timescale 1ns / 1ps

package ssal_pkg;

	// Field and register widths.
	localparam int IDX_W = 12;
	localparam int REG_W = 13;
	localparam int DEPTH = 1 << IDX_W;

	// Action codes of an input transaction.
	localparam logic [1:0] ACT_LOAD_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_LOAD_NEXT   = 2'd1;
	localparam logic [1:0] ACT_QUERY       = 2'd2;

	// Status codes of a result transaction.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_WALK_LIM  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_SAMPLE_RATE = 1'b0;
	localparam logic CFG_TEXT_LENGTH = 1'b1;

	// Register reset values.
	localparam logic [REG_W-1:0] RATE_RESET = 13'd32;
	localparam logic [REG_W-1:0] LEN_RESET  = 13'd4096;

endpackage

@@ hdl/sampled_suffix_array_lookup_top.sv @@
// Sampled suffix array lookup: sample store, next-pointer table and a
// sequencer around one shared restoring divider. Depends on ssal_pkg.
//
//   Channel | Dir | Signals                              | Transaction when
//   --------+-----+--------------------------------------+-----------------------
//   in      | in  | in_valid, in_stall, action/index/value | in_valid && !in_stall
//   out     | out | out_valid, out_stall, position/status  | out_valid && !out_stall
//   cfg     | in  | cfg_valid, cfg_ready, cfg_index/data   | cfg_valid && cfg_ready
//
// Every division (index by rate, sample and step count by length) runs on one
// restoring divider, one quotient bit per cycle, with a DW-bit dividend (DW = 13 by default).
// A next-pointer load writes the table directly; a sample load first divides the index by the rate.
// A query divides the index at each walk step, then takes sample and step count modulo the length.
// Reset is asynchronous; the stores are not cleared and read as garbage until
// written. The input stalls while a transaction is in progress; a finished
// result waits in the output register while out_stall is high.
`timescale 1ns / 1ps

module sampled_suffix_array_lookup_top #(
	parameter int MAX_WALK = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [ssal_pkg::IDX_W-1:0]    index,
	input  logic [ssal_pkg::IDX_W-1:0]    value,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ssal_pkg::IDX_W-1:0]    position,
	output logic [1:0]                    status,
	// Configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [ssal_pkg::REG_W-1:0]    cfg_data
);

	localparam int IW = ssal_pkg::IDX_W;
	localparam int RW = ssal_pkg::REG_W;
	localparam int SW = $clog2(MAX_WALK + 1);
	localparam int DW = (SW > IW) ? SW : IW;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_DIV,
		S_WALK_DIV,
		S_NEXT_RD,
		S_SAMPLE_RD,
		S_MOD_S,
		S_MOD_D,
		S_RESULT
	} state_t;

	state_t             state_q;
	logic [RW-1:0]      sample_rate_q;
	logic [RW-1:0]      text_length_q;
	logic [IW-1:0]      cur_q;
	logic [IW-1:0]      val_q;
	logic [SW-1:0]      steps_q;
	logic [RW-1:0]      s_q;
	logic [IW-1:0]      res_pos_q;
	logic [1:0]         res_stat_q;
	logic               out_valid_q;
	logic [IW-1:0]      position_q;
	logic [1:0]         status_q;

	// Shared divider registers: num holds the dividend and collects the quotient.
	logic [DW-1:0]      div_num_q;
	logic [RW:0]        div_rem_q;
	logic [RW-1:0]      div_den_q;
	logic [CW-1:0]      div_cnt_q;

	// Memories and their registered read data.
	logic [IW-1:0]      sample_mem [ssal_pkg::DEPTH];
	logic [IW-1:0]      next_mem   [ssal_pkg::DEPTH];
	logic [IW-1:0]      ss_rd_q;
	logic [IW-1:0]      nt_rd_q;

	logic               in_acc;
	logic [RW-1:0]      rate_eff;
	logic               div_done;
	logic [RW:0]        trial;
	logic               fits;
	logic [RW:0]        trial_sub;
	logic [RW-1:0]      rem;
	logic [IW-1:0]      quot;
	logic               at_limit;
	logic               ss_we;
	logic               ss_re;
	logic               nt_we;
	logic               nt_re;
	logic [RW:0]        wrap_sum;
	logic               out_free;

	// Handshake and configuration decode.
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign rate_eff  = (sample_rate_q == '0) ? RW'(1) : sample_rate_q;
	assign out_free  = !out_valid_q || !out_stall;

	// One restoring division step.
	assign div_done  = (div_cnt_q == '0);
	assign trial     = {div_rem_q[RW-1:0], div_num_q[DW-1]};
	assign fits      = (trial >= {1'b0, div_den_q});
	assign trial_sub = trial - {1'b0, div_den_q};
	assign rem       = div_rem_q[RW-1:0];
	assign quot      = div_num_q[IW-1:0];
	assign at_limit  = (steps_q >= SW'(MAX_WALK));

	// Memory port controls.
	assign nt_we = in_acc && (action == ssal_pkg::ACT_LOAD_NEXT);
	assign nt_re = (state_q == S_WALK_DIV) && div_done && (rem != '0) && !at_limit;
	assign ss_we = (state_q == S_LOAD_DIV) && div_done && (rem == '0);
	assign ss_re = (state_q == S_WALK_DIV) && div_done && (rem == '0);

	// Wrapped difference of sample and step count, both already below the length.
	assign wrap_sum = {1'b0, s_q} + ((s_q >= rem) ? '0 : {1'b0, text_length_q})
		- {1'b0, rem};

	// Next-pointer table.
	always_ff @(posedge clk) begin
		if (nt_we) begin
			next_mem[index] <= value;
		end
		if (nt_re) begin
			nt_rd_q <= next_mem[cur_q];
		end
	end

	// Sample store.
	always_ff @(posedge clk) begin
		if (ss_we) begin
			sample_mem[quot] <= val_q;
		end
		if (ss_re) begin
			ss_rd_q <= sample_mem[quot];
		end
	end

	// Sequencer, divider, configuration and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sample_rate_q <= ssal_pkg::RATE_RESET;
			text_length_q <= ssal_pkg::LEN_RESET;
			cur_q         <= '0;
			val_q         <= '0;
			steps_q       <= '0;
			s_q           <= '0;
			res_pos_q     <= '0;
			res_stat_q    <= ssal_pkg::ST_OK;
			out_valid_q   <= 1'b0;
			position_q    <= '0;
			status_q      <= ssal_pkg::ST_OK;
			div_num_q     <= '0;
			div_rem_q     <= '0;
			div_den_q     <= '0;
			div_cnt_q     <= '0;
		end else begin
			// Configuration writes.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ssal_pkg::CFG_SAMPLE_RATE) begin
					sample_rate_q <= cfg_data;
				end else begin
					text_length_q <= cfg_data;
				end
			end

			// The result register empties when the transaction completes.
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Divider iteration; a start below overrides it.
			if (!div_done) begin
				div_rem_q <= fits ? trial_sub : trial;
				div_num_q <= {div_num_q[DW-2:0], fits};
				div_cnt_q <= div_cnt_q - CW'(1);
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						val_q <= value;
						cur_q <= index;
						steps_q <= '0;
						if (action == ssal_pkg::ACT_LOAD_SAMPLE) begin
							div_num_q <= DW'(index);
							div_rem_q <= '0;
							div_den_q <= rate_eff;
							div_cnt_q <= CW'(DW);
							state_q   <= S_LOAD_DIV;
						end else if (action == ssal_pkg::ACT_QUERY) begin
							if ({1'b0, index} >= text_length_q) begin
								res_pos_q  <= '0;
								res_stat_q <= ssal_pkg::ST_RANGE;
								state_q    <= S_RESULT;
							end else begin
								div_num_q <= DW'(index);
								div_rem_q <= '0;
								div_den_q <= rate_eff;
								div_cnt_q <= CW'(DW);
								state_q   <= S_WALK_DIV;
							end
						end
					end
				end
				S_LOAD_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
					end
				end
				S_WALK_DIV: begin
					// A sampled index ends the walk; otherwise follow the pointer.
					if (div_done) begin
						if (rem == '0) begin
							state_q <= S_SAMPLE_RD;
						end else if (at_limit) begin
							res_pos_q  <= '0;
							res_stat_q <= ssal_pkg::ST_WALK_LIM;
							state_q    <= S_RESULT;
						end else begin
							state_q <= S_NEXT_RD;
						end
					end
				end
				S_NEXT_RD: begin
					cur_q     <= nt_rd_q;
					steps_q   <= steps_q + SW'(1);
					div_num_q <= DW'(nt_rd_q);
					div_rem_q <= '0;
					div_den_q <= rate_eff;
					div_cnt_q <= CW'(DW);
					state_q   <= S_WALK_DIV;
				end
				S_SAMPLE_RD: begin
					div_num_q <= DW'(ss_rd_q);
					div_rem_q <= '0;
					div_den_q <= text_length_q;
					div_cnt_q <= CW'(DW);
					state_q   <= S_MOD_S;
				end
				S_MOD_S: begin
					if (div_done) begin
						s_q       <= rem;
						div_num_q <= DW'(steps_q);
						div_rem_q <= '0;
						div_den_q <= text_length_q;
						div_cnt_q <= CW'(DW);
						state_q   <= S_MOD_D;
					end
				end
				S_MOD_D: begin
					if (div_done) begin
						res_pos_q  <= wrap_sum[IW-1:0];
						res_stat_q <= ssal_pkg::ST_OK;
						state_q    <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						position_q  <= res_pos_q;
						status_q    <= res_stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign status    = status_q;

endmodule

@@ hdl/ssal_check.sv @@
// Port-level checker for the sampled suffix array lookup top level, and the
// bind that attaches it. Depends on ssal_pkg and the top-level port list.
`timescale 1ns / 1ps

module ssal_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [1:0]                    action,
	input logic [ssal_pkg::IDX_W-1:0]    index,
	input logic [ssal_pkg::IDX_W-1:0]    value,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ssal_pkg::IDX_W-1:0]    position,
	input logic [1:0]                    status,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          cfg_index,
	input logic [ssal_pkg::REG_W-1:0]    cfg_data
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(status))
		else $error("stalled result changed");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ssal_pkg::ST_OK) || (status == ssal_pkg::ST_RANGE)
			|| (status == ssal_pkg::ST_WALK_LIM))
		else $error("undefined status code");

	// An error result carries a zero position.
	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ssal_pkg::ST_OK) |-> (position == '0))
		else $error("error result with nonzero position");

	// A load or unused action raises no result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action != ssal_pkg::ACT_QUERY) && !out_valid
		|=> !out_valid)
		else $error("result raised by a non-query transaction");

endmodule

bind sampled_suffix_array_lookup_top ssal_check u_ssal_check (.*);
